@@ rtl/core/pisq_pkg.sv @@
`default_nettype none

package pisq_pkg;

   // Field widths
   localparam int PIXEL_W  = 8;
   localparam int AREA_W   = 24;
   localparam int SQ_W     = 36;
   localparam int WORD_W   = AREA_W + SQ_W;
   localparam int SQR_W    = 2 * PIXEL_W;

   // Configuration registers
   localparam int WIDTH_REG_W  = 11;
   localparam int HEIGHT_REG_W = 12;
   localparam int CSR_IDX_W    = 1;
   localparam int CSR_DATA_W   = 12;

   localparam logic [CSR_IDX_W-1:0] CSR_ROW_WIDTH    = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_HEIGHT = 1'b1;

   localparam logic [WIDTH_REG_W-1:0]  ROW_WIDTH_RST    = 11'd640;
   localparam logic [HEIGHT_REG_W-1:0] FRAME_HEIGHT_RST = 12'd480;

   // Line buffer depth default
   localparam int DEF_MAX_WIDTH = 1024;

   // Per-pixel position flags from the position tracker
   typedef struct packed {
      logic above_valid;
      logic last_in_row;
      logic last_in_frame;
   } pos_flags_type;

endpackage

`default_nettype wire

@@ rtl/core/pisq_pos.sv @@
`default_nettype none

module pisq_pos
   import pisq_pkg::*;
#(
   parameter int MAX_WIDTH = DEF_MAX_WIDTH
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             advance,
   input  wire logic [WIDTH_REG_W-1:0]           row_width,
   input  wire logic [HEIGHT_REG_W-1:0]          frame_height,
   output logic      [$clog2(MAX_WIDTH)-1:0]     col,
   output pos_flags_type                         flags
);

   localparam int CW   = $clog2(MAX_WIDTH);
   localparam int CMPW = (CW + 1 > WIDTH_REG_W) ? CW + 1 : WIDTH_REG_W;
   localparam int RCW  = HEIGHT_REG_W + 1;

   logic [CW-1:0]           col_ff, col_in;
   logic [HEIGHT_REG_W-1:0] row_ff, row_in;
   logic [CMPW-1:0]         width_eff;
   logic [CMPW-1:0]         col_next;
   logic [RCW-1:0]          height_eff;
   logic [RCW-1:0]          row_next;
   logic                    row_end;
   logic                    frame_end;

   // Effective geometry: zero acts as one, width clamps to buffer depth
   always_comb begin
      if (row_width == '0) begin
         width_eff = CMPW'(1);
      end else if (CMPW'(row_width) > CMPW'(MAX_WIDTH)) begin
         width_eff = CMPW'(MAX_WIDTH);
      end else begin
         width_eff = CMPW'(row_width);
      end
      height_eff = (frame_height == '0) ? RCW'(1) : RCW'(frame_height);
   end

   assign col_next  = CMPW'(col_ff) + CMPW'(1);
   assign row_next  = RCW'(row_ff) + RCW'(1);
   assign row_end   = (col_next >= width_eff);
   assign frame_end = row_end && (row_next >= height_eff);

   // Position counters step once per accepted pixel
   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      if (advance) begin
         if (row_end) begin
            col_in = '0;
            row_in = frame_end ? '0 : row_next[HEIGHT_REG_W-1:0];
         end else begin
            col_in = col_next[CW-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

   assign col                 = col_ff;
   assign flags.above_valid   = (row_ff != '0);
   assign flags.last_in_row   = row_end;
   assign flags.last_in_frame = frame_end;

endmodule

`default_nettype wire

@@ rtl/core/pisq_line_buf.sv @@
`default_nettype none

module pisq_line_buf
   import pisq_pkg::*;
#(
   parameter int MAX_WIDTH = DEF_MAX_WIDTH
) (
   input  wire logic                          clock,
   input  wire logic                          rd_en,
   input  wire logic [$clog2(MAX_WIDTH)-1:0]  rd_addr,
   output logic      [WORD_W-1:0]             rd_data,
   input  wire logic                          wr_en,
   input  wire logic [$clog2(MAX_WIDTH)-1:0]  wr_addr,
   input  wire logic [WORD_W-1:0]             wr_data
);

   logic [WORD_W-1:0] mem [MAX_WIDTH];
   logic [WORD_W-1:0] rd_ff;
   logic              byp_ff;
   logic [WORD_W-1:0] byp_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Registered read; a write to the same entry at the read edge wins
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_ff       <= mem[rd_addr];
         byp_ff      <= wr_en && (wr_addr == rd_addr);
         byp_data_ff <= wr_data;
      end
   end

   assign rd_data = byp_ff ? byp_data_ff : rd_ff;

endmodule

`default_nettype wire

@@ rtl/core/pisq_accum.sv @@
`default_nettype none

module pisq_accum
   import pisq_pkg::*;
#(
   parameter int MAX_WIDTH = DEF_MAX_WIDTH
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   // accepted pixel
   input  wire logic                          load,
   input  wire logic [PIXEL_W-1:0]            pixel,
   input  wire logic [$clog2(MAX_WIDTH)-1:0]  col,
   input  wire pos_flags_type                 flags,
   output logic                               busy,
   // line buffer
   input  wire logic [WORD_W-1:0]             above_word,
   output logic                               wr_en,
   output logic      [$clog2(MAX_WIDTH)-1:0]  wr_addr,
   output logic      [WORD_W-1:0]             wr_data,
   // result register
   output logic                               out_valid,
   input  wire logic                          out_stall,
   output logic      [WORD_W-1:0]             out_word,
   output logic                               out_last_in_row,
   output logic                               out_last_in_frame
);

   localparam int CW = $clog2(MAX_WIDTH);

   logic                s1_valid_ff, s1_valid_in;
   logic [PIXEL_W-1:0]  s1_pixel_ff;
   logic [CW-1:0]       s1_col_ff;
   pos_flags_type       s1_flags_ff;

   logic [AREA_W-1:0]   run_sum_ff, run_sum_in;
   logic [SQ_W-1:0]     run_sq_ff, run_sq_in;

   logic                out_valid_ff, out_valid_in;
   logic [WORD_W-1:0]   out_word_ff;
   logic                out_row_ff;
   logic                out_frame_ff;

   logic                out_free;
   logic                s1_adv;
   logic [SQR_W-1:0]    pix_sq;
   logic [AREA_W-1:0]   sum_new;
   logic [SQ_W-1:0]     sq_new;
   logic [WORD_W-1:0]   above;
   logic [AREA_W-1:0]   area;
   logic [SQ_W-1:0]     sq;
   logic [WORD_W-1:0]   word;

   // Handshake between stage and result register
   assign out_free = !out_valid_ff || !out_stall;
   assign s1_adv   = s1_valid_ff && out_free;
   assign busy     = s1_valid_ff && !out_free;

   // Row accumulation plus the word from the row above
   assign pix_sq  = SQR_W'(s1_pixel_ff) * SQR_W'(s1_pixel_ff);
   assign sum_new = run_sum_ff + AREA_W'(s1_pixel_ff);
   assign sq_new  = run_sq_ff + SQ_W'(pix_sq);
   assign above   = s1_flags_ff.above_valid ? above_word : '0;
   assign area    = above[WORD_W-1:SQ_W] + sum_new;
   assign sq      = above[SQ_W-1:0] + sq_new;
   assign word    = {area, sq};

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (load) begin
         s1_valid_in = 1'b1;
      end else if (s1_adv) begin
         s1_valid_in = 1'b0;
      end
   end

   always_comb begin
      run_sum_in = run_sum_ff;
      run_sq_in  = run_sq_ff;
      if (s1_adv) begin
         run_sum_in = s1_flags_ff.last_in_row ? '0 : sum_new;
         run_sq_in  = s1_flags_ff.last_in_row ? '0 : sq_new;
      end
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      if (s1_adv) begin
         out_valid_in = 1'b1;
      end else if (!out_stall) begin
         out_valid_in = 1'b0;
      end
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         run_sum_ff   <= '0;
         run_sq_ff    <= '0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
         run_sum_ff   <= run_sum_in;
         run_sq_ff    <= run_sq_in;
      end
   end

   // Stage payload
   always_ff @(posedge clock) begin
      if (load) begin
         s1_pixel_ff <= pixel;
         s1_col_ff   <= col;
         s1_flags_ff <= flags;
      end
   end

   // Result payload
   always_ff @(posedge clock) begin
      if (s1_adv) begin
         out_word_ff  <= word;
         out_row_ff   <= s1_flags_ff.last_in_row;
         out_frame_ff <= s1_flags_ff.last_in_frame;
      end
   end

   assign wr_en             = s1_adv;
   assign wr_addr           = s1_col_ff;
   assign wr_data           = word;
   assign out_valid         = out_valid_ff;
   assign out_word          = out_word_ff;
   assign out_last_in_row   = out_row_ff;
   assign out_last_in_frame = out_frame_ff;

endmodule

`default_nettype wire

@@ rtl/core/packed_integral_square_integral_image_unit.sv @@
// Integral image and squared integral image of a raster pixel stream.
//
// Request channel (req_valid / req_stall / req_pixel) takes one 8-bit pixel
// per transaction in raster order. Response channel (rsp_valid / rsp_stall)
// returns one transaction per pixel: rsp_packed_value carries the area sum
// mod 2^24 in bits 59..36 and the squared sum mod 2^36 in bits 35..0, with
// rsp_last_in_row / rsp_last_in_frame marking row and frame ends.
// Configuration: csr_we writes csr_wdata to register csr_index
// (0 = row_width, 1 = frame_height); write only while the block is idle.
//
// A pixel accepted into the stage register moves on into the result register,
// which drives the response port. Throughput: one pixel per clock while the
// response is not stalled, with the line buffer read at accept and written
// through its separate write port when the stage advances.
// When the receiver stalls, the result register holds; the stage behind it
// still takes one more pixel, then req_stall rises until the result moves.
// Reset (synchronous) clears the position counters, running sums and valid
// flags and restores row_width = 640, frame_height = 480; the line buffer
// is not cleared, row 0 of each frame does not use it.
`default_nettype none

module packed_integral_square_integral_image_unit
   import pisq_pkg::*;
#(
   parameter int MAX_WIDTH = DEF_MAX_WIDTH
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   // request
   input  wire logic                     req_valid,
   output logic                          req_stall,
   input  wire logic [PIXEL_W-1:0]       req_pixel,
   // response
   output logic                          rsp_valid,
   input  wire logic                     rsp_stall,
   output logic      [WORD_W-1:0]        rsp_packed_value,
   output logic                          rsp_last_in_row,
   output logic                          rsp_last_in_frame,
   // configuration
   input  wire logic                     csr_we,
   input  wire logic [CSR_IDX_W-1:0]     csr_index,
   input  wire logic [CSR_DATA_W-1:0]    csr_wdata
);

   localparam int CW = $clog2(MAX_WIDTH);

   logic [WIDTH_REG_W-1:0]  row_width_ff;
   logic [HEIGHT_REG_W-1:0] frame_height_ff;

   logic                    accept;
   logic                    busy;
   logic [CW-1:0]           col;
   pos_flags_type           flags;
   logic [WORD_W-1:0]       above_word;
   logic                    wr_en;
   logic [CW-1:0]           wr_addr;
   logic [WORD_W-1:0]       wr_data;

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         row_width_ff    <= ROW_WIDTH_RST;
         frame_height_ff <= FRAME_HEIGHT_RST;
      end else if (csr_we) begin
         case (csr_index)
            CSR_ROW_WIDTH:    row_width_ff    <= csr_wdata[WIDTH_REG_W-1:0];
            CSR_FRAME_HEIGHT: frame_height_ff <= csr_wdata[HEIGHT_REG_W-1:0];
            default: ;
         endcase
      end
   end

   assign req_stall = busy;
   assign accept    = req_valid && !busy;

   pisq_pos #(
      .MAX_WIDTH (MAX_WIDTH)
   ) u_pos (
      .clock        (clock),
      .reset        (reset),
      .advance      (accept),
      .row_width    (row_width_ff),
      .frame_height (frame_height_ff),
      .col          (col),
      .flags        (flags)
   );

   pisq_line_buf #(
      .MAX_WIDTH (MAX_WIDTH)
   ) u_line_buf (
      .clock   (clock),
      .rd_en   (accept),
      .rd_addr (col),
      .rd_data (above_word),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data)
   );

   pisq_accum #(
      .MAX_WIDTH (MAX_WIDTH)
   ) u_accum (
      .clock             (clock),
      .reset             (reset),
      .load              (accept),
      .pixel             (req_pixel),
      .col               (col),
      .flags             (flags),
      .busy              (busy),
      .above_word        (above_word),
      .wr_en             (wr_en),
      .wr_addr           (wr_addr),
      .wr_data           (wr_data),
      .out_valid         (rsp_valid),
      .out_stall         (rsp_stall),
      .out_word          (rsp_packed_value),
      .out_last_in_row   (rsp_last_in_row),
      .out_last_in_frame (rsp_last_in_frame)
   );

endmodule

`default_nettype wire

@@ rtl/core/pisq_checker.sv @@
`default_nettype none

module pisq_checker
   import pisq_pkg::*;
(
   input wire logic                  clock,
   input wire logic                  reset,
   input wire logic                  req_valid,
   input wire logic                  req_stall,
   input wire logic                  rsp_valid,
   input wire logic                  rsp_stall,
   input wire logic [WORD_W-1:0]     rsp_packed_value,
   input wire logic                  rsp_last_in_row,
   input wire logic                  rsp_last_in_frame
);

   // Stalled response holds its transaction
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_packed_value)
         && $stable(rsp_last_in_row) && $stable(rsp_last_in_frame))
      else $error("stalled response changed");

   // A frame always ends on a row end
   a_frame_row: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_last_in_frame |-> rsp_last_in_row)
      else $error("frame end without row end");

   // Nothing comes out right after reset
   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid && !req_stall)
      else $error("output active after reset");

   // Accepted pixel passes through the stage to the response port when the
   // receiver does not stall while the pixel is in the stage
   a_latency: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall ##1 !rsp_stall |=> rsp_valid)
      else $error("response missing after accepted request");

endmodule

bind packed_integral_square_integral_image_unit pisq_checker u_pisq_checker (
   .clock             (clock),
   .reset             (reset),
   .req_valid         (req_valid),
   .req_stall         (req_stall),
   .rsp_valid         (rsp_valid),
   .rsp_stall         (rsp_stall),
   .rsp_packed_value  (rsp_packed_value),
   .rsp_last_in_row   (rsp_last_in_row),
   .rsp_last_in_frame (rsp_last_in_frame)
);

`default_nettype wire
